[design/aml_s5_sleep_type_extractor_unit_macros.svh]
// Assertion macros used by the parser of the sleep-type extractor.
`ifndef AML_S5_SLEEP_TYPE_EXTRACTOR_UNIT_MACROS_SVH
`define AML_S5_SLEEP_TYPE_EXTRACTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AML_S5_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");
`define AML_S5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in the next cycle");
`else
`define AML_S5_ASSERT_SAME(lbl, ante, cons)
`define AML_S5_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/aml_s5_pkg.sv]
`default_nettype none
package aml_s5_pkg;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_U      = 4'd1;
  localparam logic [3:0] PH_US     = 4'd2;
  localparam logic [3:0] PH_US5    = 4'd3;
  localparam logic [3:0] PH_PKGOP  = 4'd4;
  localparam logic [3:0] PH_PKGLEN = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;
  localparam logic [3:0] PH_COUNT  = 4'd7;
  localparam logic [3:0] PH_PREFIX = 4'd8;
  localparam logic [3:0] PH_BYTEV  = 4'd9;
  localparam logic [3:0] PH_WORDLO = 4'd10;
  localparam logic [3:0] PH_WORDHI = 4'd11;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_BAD_PREFIX = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_S          = 8'h53;
  localparam logic [7:0] CHAR_5          = 8'h35;
  localparam logic [7:0] OP_PACKAGE      = 8'h12;
  localparam logic [7:0] OP_BYTE_PREFIX  = 8'h0A;
  localparam logic [7:0] OP_WORD_PREFIX  = 8'h0B;
  localparam logic [7:0] OP_ZERO         = 8'h00;
  localparam logic [7:0] OP_ONE          = 8'h01;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] sleep_type_a;
    logic [15:0] sleep_type_b;
  } res_t;

endpackage
`default_nettype wire

[design/aml_s5_parser.sv]
`default_nettype none
`include "aml_s5_sleep_type_extractor_unit_macros.svh"
module aml_s5_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output aml_s5_pkg::res_t   res
);

  logic [3:0]  phase;
  logic [3:0]  phase_next;
  logic [1:0]  skip_count;
  logic [1:0]  skip_count_next;
  logic        element_index;
  logic        element_index_next;
  logic [15:0] value_first;
  logic [15:0] value_first_next;
  logic [7:0]  value_partial;
  logic [7:0]  value_partial_next;
  logic        decided;
  logic        decided_next;
  logic        head_short;
  logic        head_short_next;
  logic        store;
  logic [15:0] store_value;

  always_comb begin
    phase_next         = phase;
    skip_count_next    = skip_count;
    element_index_next = element_index;
    value_first_next   = value_first;
    value_partial_next = value_partial;
    decided_next       = decided;
    head_short_next    = head_short;
    store              = 1'b0;
    store_value        = 16'd0;
    res                = '0;

    if (!decided) begin
      unique case (phase)
        aml_s5_pkg::PH_IDLE: begin
          phase_next = (data_byte == aml_s5_pkg::CHAR_UNDERSCORE) ?
                       aml_s5_pkg::PH_U : aml_s5_pkg::PH_IDLE;
        end
        aml_s5_pkg::PH_U: begin
          if (data_byte == aml_s5_pkg::CHAR_S) begin
            phase_next = aml_s5_pkg::PH_US;
          end else if (data_byte == aml_s5_pkg::CHAR_UNDERSCORE) begin
            phase_next = aml_s5_pkg::PH_U;
          end else begin
            phase_next = aml_s5_pkg::PH_IDLE;
          end
        end
        aml_s5_pkg::PH_US: begin
          if (data_byte == aml_s5_pkg::CHAR_5) begin
            phase_next = aml_s5_pkg::PH_US5;
          end else if (data_byte == aml_s5_pkg::CHAR_UNDERSCORE) begin
            phase_next = aml_s5_pkg::PH_U;
          end else begin
            phase_next = aml_s5_pkg::PH_IDLE;
          end
        end
        aml_s5_pkg::PH_US5: begin
          phase_next = (data_byte == aml_s5_pkg::CHAR_UNDERSCORE) ?
                       aml_s5_pkg::PH_PKGOP : aml_s5_pkg::PH_IDLE;
        end
        aml_s5_pkg::PH_PKGOP: begin
          if (data_byte == aml_s5_pkg::OP_PACKAGE) begin
            phase_next = aml_s5_pkg::PH_PKGLEN;
          end else if (data_byte == aml_s5_pkg::CHAR_S) begin
            phase_next = aml_s5_pkg::PH_US;
          end else if (data_byte == aml_s5_pkg::CHAR_UNDERSCORE) begin
            phase_next = aml_s5_pkg::PH_U;
          end else begin
            phase_next = aml_s5_pkg::PH_IDLE;
          end
        end
        aml_s5_pkg::PH_PKGLEN: begin
          skip_count_next = data_byte[7:6];
          head_short_next = (data_byte[7:6] == 2'd0);
          phase_next      = (data_byte[7:6] == 2'd0) ?
                            aml_s5_pkg::PH_COUNT : aml_s5_pkg::PH_SKIP;
        end
        aml_s5_pkg::PH_SKIP: begin
          skip_count_next = skip_count - 2'd1;
          if (skip_count == 2'd1) begin
            phase_next = aml_s5_pkg::PH_COUNT;
          end
        end
        aml_s5_pkg::PH_COUNT: begin
          element_index_next = 1'b0;
          phase_next         = aml_s5_pkg::PH_PREFIX;
        end
        aml_s5_pkg::PH_PREFIX: begin
          if (data_byte == aml_s5_pkg::OP_BYTE_PREFIX) begin
            phase_next = aml_s5_pkg::PH_BYTEV;
          end else if (data_byte == aml_s5_pkg::OP_WORD_PREFIX) begin
            phase_next = aml_s5_pkg::PH_WORDLO;
          end else if (data_byte == aml_s5_pkg::OP_ZERO ||
                       data_byte == aml_s5_pkg::OP_ONE) begin
            store       = 1'b1;
            store_value = {8'd0, data_byte};
          end else if (last_byte && !element_index && head_short) begin
            // The match began too close to the end of the stream to count.
            phase_next = aml_s5_pkg::PH_IDLE;
          end else begin
            res.valid    = 1'b1;
            res.status   = aml_s5_pkg::STATUS_BAD_PREFIX;
            decided_next = 1'b1;
            phase_next   = aml_s5_pkg::PH_IDLE;
          end
        end
        aml_s5_pkg::PH_BYTEV: begin
          store       = 1'b1;
          store_value = {8'd0, data_byte};
        end
        aml_s5_pkg::PH_WORDLO: begin
          value_partial_next = data_byte;
          phase_next         = aml_s5_pkg::PH_WORDHI;
        end
        aml_s5_pkg::PH_WORDHI: begin
          store       = 1'b1;
          store_value = {data_byte, value_partial};
        end
        default: begin
          phase_next = aml_s5_pkg::PH_IDLE;
        end
      endcase
    end

    if (store) begin
      if (!element_index) begin
        value_first_next   = store_value;
        element_index_next = 1'b1;
        phase_next         = aml_s5_pkg::PH_PREFIX;
      end else begin
        res.valid        = 1'b1;
        res.status       = aml_s5_pkg::STATUS_FOUND;
        res.sleep_type_a = value_first;
        res.sleep_type_b = store_value;
        decided_next     = 1'b1;
        phase_next       = aml_s5_pkg::PH_IDLE;
      end
    end

    if (last_byte) begin
      if (!decided && !res.valid) begin
        res.valid  = 1'b1;
        res.status = aml_s5_pkg::STATUS_NOT_FOUND;
      end
      phase_next         = aml_s5_pkg::PH_IDLE;
      skip_count_next    = 2'd0;
      element_index_next = 1'b0;
      value_first_next   = 16'd0;
      value_partial_next = 8'd0;
      decided_next       = 1'b0;
      head_short_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= aml_s5_pkg::PH_IDLE;
      skip_count    <= 2'd0;
      element_index <= 1'b0;
      value_first   <= 16'd0;
      value_partial <= 8'd0;
      decided       <= 1'b0;
      head_short    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      skip_count    <= skip_count_next;
      element_index <= element_index_next;
      value_first   <= value_first_next;
      value_partial <= value_partial_next;
      decided       <= decided_next;
      head_short    <= head_short_next;
    end
  end

  `AML_S5_ASSERT_NEXT(a_decided_holds, step && decided && !last_byte, decided)
  `AML_S5_ASSERT_NEXT(a_last_rearms, step && last_byte,
                      phase == aml_s5_pkg::PH_IDLE && !decided)
  `AML_S5_ASSERT_SAME(a_error_values_zero,
                      res.valid && res.status != aml_s5_pkg::STATUS_FOUND,
                      res.sleep_type_a == 16'd0 && res.sleep_type_b == 16'd0)
  `AML_S5_ASSERT_SAME(a_one_result_per_stream,
                      res.valid, !decided)

endmodule
`default_nettype wire

[design/aml_s5_out_reg.sv]
`default_nettype none
module aml_s5_out_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire aml_s5_pkg::res_t res,
  output logic              free,
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic [1:0]        status,
  output logic [15:0]       sleep_type_a,
  output logic [15:0]       sleep_type_b
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && res.valid) begin
      status       <= res.status;
      sleep_type_a <= res.sleep_type_a;
      sleep_type_b <= res.sleep_type_b;
    end
  end

endmodule
`default_nettype wire

[design/aml_s5_sleep_type_extractor_unit.sv]
// A byte is captured in the input register, stepped through the parser and its
// result is registered in the result register. Throughput: one byte per cycle;
// a result waiting at the output stalls the input until it is transferred out.
// Reset (synchronous, active high) returns the parser to the search for the
// first underscore and empties the input and result registers.
`default_nettype none
module aml_s5_sleep_type_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       status,
  output logic [15:0]      sleep_type_a,
  output logic [15:0]      sleep_type_b
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             held_last;
  logic             free;
  logic             step;
  aml_s5_pkg::res_t res;

  assign step       = held_valid && free;
  assign item_ready = !held_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

  aml_s5_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (held_byte),
    .last_byte (held_last),
    .res       (res)
  );

  aml_s5_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .sleep_type_a (sleep_type_a),
    .sleep_type_b (sleep_type_b)
  );

endmodule
`default_nettype wire

[tb/aml_s5_result_checker.sv]
`default_nettype none
module aml_s5_result_checker
  import aml_s5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire logic        item_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        result_valid,
  input  wire logic        result_ready,
  input  wire logic [1:0]  status,
  input  wire logic [15:0] sleep_type_a,
  input  wire logic [15:0] sleep_type_b,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] type_a;
    logic [15:0] type_b;
  } sleep_report_t;

  sleep_report_t expected_reports[$];

  logic [3:0]  phase;
  logic [1:0]  skip_left;
  logic        elem_idx;
  logic [15:0] first_val;
  logic [15:0] low_val;
  logic        done;
  logic        short_head;
  int          mismatches = 0;

  function automatic void rearm();
    phase      = PH_IDLE;
    skip_left  = 2'd0;
    elem_idx   = 1'b0;
    first_val  = 16'd0;
    low_val    = 16'd0;
    done       = 1'b0;
    short_head = 1'b0;
  endfunction

  function automatic logic [3:0] restart_from(input logic [7:0] b);
    return (b == CHAR_UNDERSCORE) ? PH_U : PH_IDLE;
  endfunction

  function automatic void take_element(input logic [15:0] v);
    if (!elem_idx) begin
      first_val = v;
      elem_idx  = 1'b1;
      phase     = PH_PREFIX;
    end else begin
      expected_reports.push_back('{STATUS_FOUND, first_val, v});
      done  = 1'b1;
      phase = PH_IDLE;
    end
  endfunction

  function automatic void parse_aml_byte(input logic [7:0] b, input logic lst);
    if (!done) begin
      case (phase)
        PH_IDLE:   phase = restart_from(b);
        PH_U:      phase = (b == CHAR_S) ? PH_US : restart_from(b);
        PH_US:     phase = (b == CHAR_5) ? PH_US5 : restart_from(b);
        PH_US5:    phase = (b == CHAR_UNDERSCORE) ? PH_PKGOP : PH_IDLE;
        PH_PKGOP: begin
          if (b == OP_PACKAGE) phase = PH_PKGLEN;
          else if (b == CHAR_S) phase = PH_US;
          else phase = restart_from(b);
        end
        PH_PKGLEN: begin
          skip_left  = b[7:6];
          short_head = (b[7:6] == 2'd0);
          phase      = short_head ? PH_COUNT : PH_SKIP;
        end
        PH_SKIP: begin
          skip_left = skip_left - 2'd1;
          if (skip_left == 2'd0) phase = PH_COUNT;
        end
        PH_COUNT: begin
          elem_idx = 1'b0;
          phase    = PH_PREFIX;
        end
        PH_PREFIX: begin
          if (b == OP_BYTE_PREFIX) begin
            phase = PH_BYTEV;
          end else if (b == OP_WORD_PREFIX) begin
            phase = PH_WORDLO;
          end else if (b == OP_ZERO || b == OP_ONE) begin
            take_element({8'h00, b});
          end else if (lst && !elem_idx && short_head) begin
            // A match that starts this close to the end does not count.
            phase = PH_IDLE;
          end else begin
            expected_reports.push_back('{STATUS_BAD_PREFIX, 16'd0, 16'd0});
            done  = 1'b1;
            phase = PH_IDLE;
          end
        end
        PH_BYTEV:  take_element({8'h00, b});
        PH_WORDLO: begin
          low_val = {8'h00, b};
          phase   = PH_WORDHI;
        end
        PH_WORDHI: take_element({b, low_val[7:0]});
        default:   phase = PH_IDLE;
      endcase
    end
    if (lst) begin
      if (!done) expected_reports.push_back('{STATUS_NOT_FOUND, 16'd0, 16'd0});
      rearm();
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_val,
                                      input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    sleep_report_t head;
    if (rst) begin
      rearm();
      expected_reports.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result transfer: status %0d, a %0h, b %0h",
                 status, sleep_type_a, sleep_type_b);
          mismatches++;
        end else begin
          head = expected_reports.pop_front();
          check_field("status", {14'd0, head.status}, {14'd0, status});
          check_field("sleep_type_a", head.type_a, sleep_type_a);
          check_field("sleep_type_b", head.type_b, sleep_type_b);
        end
      end
      if (item_valid && item_ready) parse_aml_byte(data_byte, last_byte);
      outstanding <= expected_reports.size();
    end
    fail_count <= mismatches;
  end

endmodule
`default_nettype wire

[tb/tb_aml_s5_sleep_type_extractor_unit.sv]
`default_nettype none
module tb_aml_s5_sleep_type_extractor_unit
  import aml_s5_pkg::*;
();

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] sleep_type_a;
  logic [15:0] sleep_type_b;

  int          fail_count;
  int          outstanding;
  int          cycles = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          mode_left = 0;
  logic [2:0]  stall_phase = 3'd0;
  logic [7:0]  stream_bytes[$];

  aml_s5_sleep_type_extractor_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .sleep_type_a (sleep_type_a),
    .sleep_type_b (sleep_type_b)
  );

  aml_s5_result_checker u_result_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .sleep_type_a (sleep_type_a),
    .sleep_type_b (sleep_type_b),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 60);
      end
      mode_left--;
      stall_phase <= stall_phase + 3'd1;
      case (ready_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= ($urandom_range(0, 3) == 0);
        default: result_ready <= (stall_phase[2:1] != 2'd0);
      endcase
    end
  end

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 11))
      0:       return CHAR_UNDERSCORE;
      1:       return CHAR_S;
      2:       return CHAR_5;
      3:       return OP_PACKAGE;
      4:       return OP_BYTE_PREFIX;
      5:       return OP_WORD_PREFIX;
      6:       return OP_ZERO;
      7:       return OP_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    item_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= lst;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_stream();
    for (int k = 0; k < stream_bytes.size(); k++)
      put_byte(stream_bytes[k], k == stream_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic build_stream();
    int         pick;
    int         cut;
    logic [7:0] lead;
    logic [7:0] bad;
    stream_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      repeat ($urandom_range(0, 3)) stream_bytes.push_back(noise_byte());
      case ($urandom_range(0, 5))
        1: stream_bytes.push_back(CHAR_UNDERSCORE);
        2: stream_bytes = {stream_bytes, CHAR_UNDERSCORE, CHAR_S};
        3: stream_bytes = {stream_bytes, CHAR_UNDERSCORE, CHAR_S, CHAR_5};
        default: ;
      endcase
      stream_bytes = {stream_bytes, CHAR_UNDERSCORE, CHAR_S, CHAR_5, CHAR_UNDERSCORE};
      stream_bytes.push_back(($urandom_range(0, 19) != 0) ? OP_PACKAGE : noise_byte());
      lead = 8'($urandom_range(0, 255));
      if (pick < 25) lead[7:6] = 2'd0;
      stream_bytes.push_back(lead);
      repeat (lead[7:6]) stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'h02 : 8'($urandom_range(0, 255)));
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: stream_bytes = {stream_bytes, OP_BYTE_PREFIX, 8'($urandom_range(0, 255))};
          3, 4, 5: stream_bytes = {stream_bytes, OP_WORD_PREFIX, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255))};
          6, 7:    stream_bytes.push_back(OP_ZERO);
          8:       stream_bytes.push_back(OP_ONE);
          default: begin
            do bad = 8'($urandom_range(0, 255));
            while (bad == OP_ZERO || bad == OP_ONE || bad == OP_BYTE_PREFIX ||
                   bad == OP_WORD_PREFIX);
            stream_bytes.push_back(bad);
          end
        endcase
      end
      repeat ($urandom_range(0, 3)) stream_bytes.push_back(noise_byte());
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, stream_bytes.size());
        while (stream_bytes.size() > cut) stream_bytes.delete(stream_bytes.size() - 1);
      end
    end else if (pick < 87) begin
      // Unsupported prefix as the final byte, mostly right after a short head.
      stream_bytes = {CHAR_UNDERSCORE, CHAR_S, CHAR_5, CHAR_UNDERSCORE, OP_PACKAGE};
      lead = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 2) != 0) lead[7:6] = 2'd0;
      stream_bytes.push_back(lead);
      repeat (lead[7:6]) stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) stream_bytes.push_back(OP_ONE);
      do bad = 8'($urandom_range(0, 255));
      while (bad == OP_ZERO || bad == OP_ONE || bad == OP_BYTE_PREFIX ||
             bad == OP_WORD_PREFIX);
      stream_bytes.push_back(bad);
    end else begin
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(noise_byte());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    stream_bytes = {CHAR_UNDERSCORE, CHAR_S, CHAR_5, CHAR_UNDERSCORE, OP_PACKAGE, 8'hC0,
                    8'hAA, 8'hBB, 8'hCC, 8'h04, OP_ZERO, OP_ONE};
    send_stream();
    stream_bytes = {CHAR_UNDERSCORE, CHAR_S, CHAR_5, CHAR_UNDERSCORE, OP_PACKAGE, 8'h00,
                    8'h02, OP_WORD_PREFIX, 8'hFF, 8'hFF, OP_BYTE_PREFIX, 8'h80};
    send_stream();
    stream_bytes = {8'h33};
    send_stream();
    wait_idle();

    for (int s = 0; sent_items < ITEM_TARGET; s++) begin
      build_stream();
      send_stream();
      if (s % 15 == 14) wait_idle();
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
